// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Self-contained; no other file required.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hsc assertion failed");

// Next-cycle implication, disabled while reset is low.
`define HSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hsc assertion failed");

`endif

// File: rtl/hsc_pkg.sv
// Types, constants and position tables for the Hamming SECDED codec.
// Used by hsc_codec, hamming_secded_codec and hsc_checker.
package hsc_pkg;

  localparam int MAX_DATA_BITS = 26;
  localparam int DATA_W        = 26;
  localparam int CW_W          = 31;
  localparam int POS_W         = 5;
  localparam int CHK_MAX       = 5;
  localparam int CHK_CNT_W     = 3;
  localparam int STATUS_W      = 2;
  localparam int APB_DW        = 32;
  localparam int APB_AW        = 3;

  localparam logic REG_ODD_PARITY = 1'b0;
  localparam logic REG_DATA_BITS  = 1'b1;

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_DOUBLE    = 2'd2
  } status_e;

  typedef struct packed {
    logic             odd_parity;
    logic [POS_W-1:0] data_bits;
  } cfg_t;

  typedef struct packed {
    logic [CW_W-1:0]  codeword;
    logic             extra_parity;
    status_e          status;
    logic [POS_W-1:0] error_position;
  } res_t;

  // Codeword bits whose Hamming position has bit k set.
  function automatic logic [CW_W-1:0] cover_mask(input int k);
    logic [CW_W-1:0] m;
    m = '0;
    for (int i = 0; i < CW_W; i++) begin
      m[i] = (((i + 1) >> k) & 1) != 0;
    end
    return m;
  endfunction

  function automatic logic is_pow2(input int pos);
    return (pos & (pos - 1)) == 0;
  endfunction

  // Message bit carried at a non-power-of-two position.
  function automatic logic [POS_W-1:0] data_index(input int pos);
    int idx;
    idx = 0;
    for (int p = 1; p < pos; p++) begin
      if (!is_pow2(p)) begin
        idx = idx + 1;
      end
    end
    return idx[POS_W-1:0];
  endfunction

endpackage

// File: rtl/hsc_codec.sv
// Single-pass encode / syndrome-decode logic of the SECDED codec.
// Depends on hsc_pkg for the position tables and result types.
module hsc_codec (
  input  hsc_pkg::cfg_t                 cfg_i,
  input  hsc_pkg::kind_e                kind_i,
  input  logic [hsc_pkg::DATA_W-1:0]    data_in_i,
  input  logic [hsc_pkg::CW_W-1:0]      codeword_in_i,
  input  logic                          extra_parity_in_i,
  output hsc_pkg::res_t                 res_o
);
  import hsc_pkg::*;

  logic [POS_W-1:0]     d_eff;
  logic [CHK_CNT_W-1:0] p_cnt;
  logic [POS_W:0]       n_sum;
  logic [POS_W-1:0]     n_len;
  logic [CW_W-1:0]      nmask;
  logic [CW_W-1:0]      enc_raw;
  logic [CW_W-1:0]      enc_cw;
  logic [CW_W-1:0]      dec_cw;
  logic [CW_W-1:0]      flip;
  logic [CHK_MAX-1:0]   enc_chk;
  logic [CHK_MAX-1:0]   syn;
  logic                 overall;

  // Clamp length and derive check count and codeword length.
  always_comb begin
    priority if (cfg_i.data_bits == '0) begin
      d_eff = POS_W'(1);
    end else if (cfg_i.data_bits > POS_W'(MAX_DATA_BITS)) begin
      d_eff = POS_W'(MAX_DATA_BITS);
    end else begin
      d_eff = cfg_i.data_bits;
    end
    priority if (d_eff == POS_W'(1)) begin
      p_cnt = CHK_CNT_W'(2);
    end else if (d_eff <= POS_W'(4)) begin
      p_cnt = CHK_CNT_W'(3);
    end else if (d_eff <= POS_W'(11)) begin
      p_cnt = CHK_CNT_W'(4);
    end else begin
      p_cnt = CHK_CNT_W'(5);
    end
    n_sum = {1'b0, d_eff} + {{(POS_W + 1 - CHK_CNT_W){1'b0}}, p_cnt};
    n_len = n_sum[POS_W-1:0];
    for (int i = 0; i < CW_W; i++) begin
      nmask[i] = (POS_W + 1)'(i + 1) <= n_sum;
    end
  end

  // Encode: scatter message bits, then fill check positions.
  always_comb begin
    for (int i = 0; i < CW_W; i++) begin
      if (is_pow2(i + 1)) begin
        enc_raw[i] = 1'b0;
      end else begin
        enc_raw[i] = data_in_i[data_index(i + 1)] & nmask[i];
      end
    end
    enc_cw = enc_raw;
    for (int k = 0; k < CHK_MAX; k++) begin
      enc_chk[k] = (CHK_CNT_W'(k) < p_cnt) &
                   ((^(enc_raw & cover_mask(k))) ^ cfg_i.odd_parity);
      enc_cw[(1 << k) - 1] = enc_chk[k];
    end
  end

  // Decode: syndrome against chosen parity, then overall parity.
  always_comb begin
    dec_cw = codeword_in_i & nmask;
    for (int k = 0; k < CHK_MAX; k++) begin
      syn[k] = (CHK_CNT_W'(k) < p_cnt) &
               ((^(dec_cw & cover_mask(k))) ^ cfg_i.odd_parity);
    end
    overall = (^dec_cw) ^ extra_parity_in_i;
    for (int i = 0; i < CW_W; i++) begin
      flip[i] = syn == POS_W'(i + 1);
    end
  end

  always_comb begin
    res_o = '0;
    unique case (kind_i)
      KIND_ENCODE: begin
        res_o.codeword       = enc_cw;
        res_o.status         = ST_OK;
        res_o.error_position = '0;
      end
      KIND_DECODE: begin
        res_o.error_position = syn;
        res_o.codeword       = dec_cw;
        priority if (syn == '0) begin
          res_o.status = overall ? ST_CORRECTED : ST_OK;
        end else if (!overall) begin
          res_o.status = ST_DOUBLE;
        end else if (syn > n_len) begin
          res_o.status = ST_DOUBLE;
        end else begin
          res_o.codeword = dec_cw ^ flip;
          res_o.status   = ST_CORRECTED;
        end
      end
      default: begin
        res_o.status = ST_OK;
      end
    endcase
    res_o.extra_parity = ^res_o.codeword;
  end

endmodule

// File: rtl/hamming_secded_codec.sv
// Hamming SECDED codec: input register, single-pass codec logic, result register.
// An accepted input beat is held in the input register, then its result in the result register, before it is offered.
// Throughput: one beat per cycle; the input stalls only while the input register is full and the
// result register is stalled.
// Reset clears both valid flags and sets even parity with 4 data bits.
// Depends on hsc_pkg and hsc_codec.
module hamming_secded_codec (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hsc_pkg::kind_e                 kind_i,
  input  logic [hsc_pkg::DATA_W-1:0]     data_in_i,
  input  logic [hsc_pkg::CW_W-1:0]       codeword_in_i,
  input  logic                           extra_parity_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hsc_pkg::CW_W-1:0]       codeword_out_o,
  output logic                           extra_parity_out_o,
  output logic [hsc_pkg::STATUS_W-1:0]   status_o,
  output logic [hsc_pkg::POS_W-1:0]      error_position_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hsc_pkg::APB_AW-1:0]     paddr,
  input  logic [hsc_pkg::APB_DW-1:0]     pwdata,
  output logic [hsc_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import hsc_pkg::*;

  cfg_t              cfg_q;
  logic              s1_valid_q;
  kind_e             s1_kind_q;
  logic [DATA_W-1:0] s1_data_q;
  logic [CW_W-1:0]   s1_cw_q;
  logic              s1_extra_q;
  logic              out_valid_q;
  res_t              res_d;
  res_t              res_q;
  logic              out_en;
  logic              in_en;
  logic              cfg_wr;

  // Register file.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.odd_parity <= 1'b0;
      cfg_q.data_bits  <= POS_W'(4);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ODD_PARITY: cfg_q.odd_parity <= pwdata[0];
        REG_DATA_BITS:  cfg_q.data_bits  <= pwdata[POS_W-1:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ODD_PARITY: prdata[0]         = cfg_q.odd_parity;
      REG_DATA_BITS:  prdata[POS_W-1:0] = cfg_q.data_bits;
      default:        prdata            = '0;
    endcase
  end

  // Advance each stage when the one after it is empty or moving.
  assign out_en     = !out_valid_q || !out_stall_i;
  assign in_en      = !s1_valid_q || out_en;
  assign in_stall_o = !in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && in_valid_i) begin
      s1_kind_q  <= kind_i;
      s1_data_q  <= data_in_i;
      s1_cw_q    <= codeword_in_i;
      s1_extra_q <= extra_parity_in_i;
    end
    if (out_en && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  hsc_codec u_codec (
    .cfg_i             (cfg_q),
    .kind_i            (s1_kind_q),
    .data_in_i         (s1_data_q),
    .codeword_in_i     (s1_cw_q),
    .extra_parity_in_i (s1_extra_q),
    .res_o             (res_d)
  );

  assign out_valid_o        = out_valid_q;
  assign codeword_out_o     = res_q.codeword;
  assign extra_parity_out_o = res_q.extra_parity;
  assign status_o           = res_q.status;
  assign error_position_o   = res_q.error_position;

endmodule

// File: rtl/hsc_checker.sv
// Port-level checks for hamming_secded_codec, attached by bind.
// Depends on hsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hsc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [hsc_pkg::CW_W-1:0]       codeword_out_o,
  input logic                           extra_parity_out_o,
  input logic [hsc_pkg::STATUS_W-1:0]   status_o,
  input logic [hsc_pkg::POS_W-1:0]      error_position_o
);
  import hsc_pkg::*;

  // A stalled result beat stays offered.
  `HSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Overall parity always matches the delivered codeword.
  `HSC_ASSERT_IMPLY(a_parity, clk_i, rst_ni, out_valid_o, extra_parity_out_o == ^codeword_out_o)

  // A clean result reports no position.
  `HSC_ASSERT_IMPLY(a_ok_pos, clk_i, rst_ni, out_valid_o && (status_o == ST_OK), error_position_o == '0)

  // With the result register empty the input side never stalls.
  `HSC_ASSERT_IMPLY(a_no_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o)

endmodule

bind hamming_secded_codec hsc_checker u_hsc_checker (.*);

// File: sim/tb_hamming_secded_codec.sv
// Self-checking testbench for hamming_secded_codec: encode and check/correct beats
// against an in-bench SECDED predictor, across parity modes and message lengths.
// Depends on hsc_pkg and the codec RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_hamming_secded_codec;
  import hsc_pkg::*;

  localparam int CODEC_LATENCY  = 2;
  localparam int MAX_GAP        = 18;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RAND_PHASES    = 14;
  localparam int BEATS_PER_PHASE = 132;

  localparam logic [APB_AW-1:0] ADDR_ODD_PARITY = {REG_ODD_PARITY, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_DATA_BITS  = {REG_DATA_BITS, 2'b00};

  // {odd_parity, data_bits} pairs run first: shortest, longest, both clamp cases
  localparam logic [5:0] EDGE_CFGS [7] = '{6'h01, 6'h3A, 6'h00, 6'h3F, 6'h1B, 6'h24, 6'h05};

  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] data;
    logic [CW_W-1:0]   cw;
    logic              xp;
  } beat_t;

  class secded_scoreboard;
    res_t        expected_words[$];
    logic        odd_mode;
    logic [4:0]  dbits_reg;
    int          errors;

    function new();
      odd_mode  = 1'b0;
      dbits_reg = 5'd4;
      errors    = 0;
    endfunction

    function void set_config(logic odd, logic [4:0] dbits);
      odd_mode  = odd;
      dbits_reg = dbits;
    endfunction

    function int msg_len();
      if (dbits_reg < 1) return 1;
      if (dbits_reg > MAX_DATA_BITS) return MAX_DATA_BITS;
      return dbits_reg;
    endfunction

    function int check_bits();
      int r;
      r = 0;
      while ((1 << r) < msg_len() + r + 1) r++;
      return r;
    endfunction

    function int word_len();
      return msg_len() + check_bits();
    endfunction

    function logic [CW_W-1:0] word_mask();
      logic [31:0] m;
      m = (32'd1 << word_len()) - 32'd1;
      return m[CW_W-1:0];
    endfunction

    // positions 1..n whose index has bit k set
    function logic [CW_W-1:0] parity_group(int k, int n);
      logic [CW_W-1:0] m;
      m = '0;
      for (int pos = 1; pos <= n; pos++) begin
        if ((pos >> k) & 1) m[pos-1] = 1'b1;
      end
      return m;
    endfunction

    function res_t secded_result(kind_e kind, logic [DATA_W-1:0] data,
                                 logic [CW_W-1:0] cw_in, logic xp_in);
      res_t            r;
      int              n, p, di;
      logic [CW_W-1:0] cw;
      logic [4:0]      syn;
      logic            overall;
      status_e         st;
      n   = word_len();
      p   = check_bits();
      syn = '0;
      st  = ST_OK;
      if (kind == KIND_ENCODE) begin
        cw = '0;
        di = 0;
        for (int pos = 1; pos <= n; pos++) begin
          if ((pos & (pos - 1)) != 0) begin
            cw[pos-1] = data[di];
            di++;
          end
        end
        for (int k = 0; k < p; k++) begin
          if ((^(cw & parity_group(k, n))) ^ odd_mode) cw[(1 << k) - 1] = 1'b1;
        end
      end else begin
        cw = cw_in & word_mask();
        for (int k = 0; k < p; k++) begin
          syn[k] = (^(cw & parity_group(k, n))) ^ odd_mode;
        end
        overall = (^cw) ^ xp_in;
        if (syn == 0) begin
          st = overall ? ST_CORRECTED : ST_OK;
        end else if (!overall || syn > n) begin
          // even flip count, or a syndrome past the end of the word
          st = ST_DOUBLE;
        end else begin
          cw[syn-1] = ~cw[syn-1];
          st = ST_CORRECTED;
        end
      end
      r.codeword       = cw;
      r.extra_parity   = ^cw;
      r.status         = st;
      r.error_position = syn;
      return r;
    endfunction

    function void note_input(beat_t b);
      expected_words.push_back(secded_result(b.kind, b.data, b.cw, b.xp));
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void check_result(res_t got);
      res_t exp_word;
      if (expected_words.size() == 0) begin
        $error("result beat with nothing outstanding: codeword_out %0h", got.codeword);
        errors++;
        return;
      end
      exp_word = expected_words.pop_front();
      if (got.codeword !== exp_word.codeword) begin
        $error("codeword_out: expected %0h, got %0h", exp_word.codeword, got.codeword);
        errors++;
      end
      if (got.extra_parity !== exp_word.extra_parity) begin
        $error("extra_parity_out: expected %0b, got %0b",
               exp_word.extra_parity, got.extra_parity);
        errors++;
      end
      if (got.status !== exp_word.status) begin
        $error("status: expected %0d, got %0d", exp_word.status, got.status);
        errors++;
      end
      if (got.error_position !== exp_word.error_position) begin
        $error("error_position: expected %0d, got %0d",
               exp_word.error_position, got.error_position);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  kind_e               kind_i;
  logic [DATA_W-1:0]   data_in_i;
  logic [CW_W-1:0]     codeword_in_i;
  logic                extra_parity_in_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CW_W-1:0]     codeword_out_o;
  logic                extra_parity_out_o;
  logic [STATUS_W-1:0] status_o;
  logic [POS_W-1:0]    error_position_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  secded_scoreboard sb;
  int   cycle_count = 0;
  logic send_quiet  = 1'b0;
  logic recv_quiet  = 1'b0;

  hamming_secded_codec dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .data_in_i          (data_in_i),
    .codeword_in_i      (codeword_in_i),
    .extra_parity_in_i  (extra_parity_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .codeword_out_o     (codeword_out_o),
    .extra_parity_out_o (extra_parity_out_o),
    .status_o           (status_o),
    .error_position_o   (error_position_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic odd, input logic [4:0] dbits);
    reg_write(ADDR_ODD_PARITY, {{(APB_DW-1){1'b0}}, odd});
    reg_write(ADDR_DATA_BITS, {{(APB_DW-5){1'b0}}, dbits});
    sb.set_config(odd, dbits);
  endtask

  task automatic drive_beat(input beat_t b);
    int gap;
    if ($urandom_range(0, 49) == 0) send_quiet = ~send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= b.kind;
    data_in_i         <= b.data;
    codeword_in_i     <= b.cw;
    extra_parity_in_i <= b.xp;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b);
  endtask

  // drop valid and hold off until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (CODEC_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic receive_results();
    int   gap;
    res_t got;
    forever begin
      if ($urandom_range(0, 39) == 0) recv_quiet = ~recv_quiet;
      gap = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk_i);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.codeword       = codeword_out_o;
      got.extra_parity   = extra_parity_out_o;
      got.status         = status_e'(status_o);
      got.error_position = error_position_o;
      sb.check_result(got);
    end
  endtask

  function automatic beat_t make_encode(input logic [DATA_W-1:0] data);
    beat_t b;
    b.kind = KIND_ENCODE;
    b.data = data;
    b.cw   = CW_W'($urandom());
    b.xp   = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // build a clean codeword for the current setting, then damage it
  function automatic beat_t make_decode(input logic [DATA_W-1:0] data, input int flip_a,
                                        input int flip_b, input logic flip_xp,
                                        input logic [CW_W-1:0] noise);
    res_t  enc;
    beat_t b;
    enc    = sb.secded_result(KIND_ENCODE, data, '0, 1'b0);
    b.kind = KIND_DECODE;
    b.data = DATA_W'($urandom());
    b.cw   = enc.codeword ^ noise;
    b.xp   = enc.extra_parity ^ flip_xp;
    if (flip_a > 0) b.cw[flip_a-1] = ~b.cw[flip_a-1];
    if (flip_b > 0) b.cw[flip_b-1] = ~b.cw[flip_b-1];
    return b;
  endfunction

  function automatic beat_t random_beat();
    int              n, sel, pa, pb;
    logic [DATA_W-1:0] data;
    logic [CW_W-1:0] noise;
    beat_t           b;
    n     = sb.word_len();
    sel   = $urandom_range(0, 99);
    data  = DATA_W'($urandom());
    noise = $urandom_range(0, 1) ? (CW_W'($urandom()) & ~sb.word_mask()) : '0;
    pa    = $urandom_range(1, n);
    do pb = $urandom_range(1, n); while (pb == pa);
    if (sel < 30) begin
      b = make_encode(data);
    end else if (sel < 45) begin
      b = make_decode(data, 0, 0, 1'b0, noise);
    end else if (sel < 70) begin
      b = make_decode(data, pa, 0, 1'b0, noise);
    end else if (sel < 78) begin
      b = make_decode(data, 0, 0, 1'b1, noise);
    end else if (sel < 90) begin
      b = make_decode(data, pa, pb, $urandom_range(0, 1) == 0, noise);
    end else begin
      b.kind = KIND_DECODE;
      b.data = data;
      b.cw   = CW_W'($urandom());
      b.xp   = 1'($urandom_range(0, 1));
    end
    return b;
  endfunction

  task automatic run_directed();
    // reset setting: even parity, four message bits
    drive_beat(make_encode('0));
    drive_beat(make_encode('1));
    drive_beat(make_decode(26'hA, 0, 0, 1'b0, '0));
    drive_beat(make_decode(26'h5, 3, 0, 1'b0, '0));
    drive_beat(make_decode(26'h9, 0, 0, 1'b1, '0));
    drain_results();
    set_config(1'b1, 5'd26);
    drive_beat(make_encode('0));
    drive_beat(make_encode('1));
    drive_beat(make_encode(26'h2AAAAAA));
    drive_beat(make_decode('1, 0, 0, 1'b0, '0));
    drive_beat(make_decode('1, 31, 0, 1'b0, '0));
    drive_beat(make_decode(26'h1234567, 1, 0, 1'b0, '0));
    drive_beat(make_decode(26'h0F0F0F0, 16, 0, 1'b0, '0));
    drive_beat(make_decode(26'h3C3C3C3, 0, 0, 1'b1, '0));
    drive_beat(make_decode(26'h1555555, 5, 20, 1'b0, '0));
    drive_beat(make_decode(26'h0000001, 1, 2, 1'b0, '0));
    drive_beat('{KIND_DECODE, '0, '1, 1'b0});
    drive_beat('{KIND_DECODE, '1, '0, 1'b1});
    drain_results();
    // nine-bit word: syndromes 10..15 point past the end
    set_config(1'b0, 5'd5);
    drive_beat(make_encode('1));
    drive_beat(make_decode(26'h15, 0, 0, 1'b0, 31'h7FFFFE00));
    drive_beat(make_decode(26'h0A, 8, 3, 1'b1, '0));
    drive_beat(make_decode(26'h1F, 2, 7, 1'b0, '0));
    drive_beat(make_decode(26'h11, 9, 0, 1'b0, '0));
    drain_results();
    set_config(1'b1, 5'd0);
    drive_beat(make_encode(26'h1));
    drive_beat(make_decode(26'h1, 2, 0, 1'b0, '0));
    drain_results();
    set_config(1'b0, 5'd31);
    drive_beat(make_encode('1));
    drain_results();
  endtask

  task automatic run_random();
    logic       odd;
    logic [4:0] dbits;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 7) begin
        {odd, dbits} = EDGE_CFGS[ph];
      end else begin
        odd   = 1'($urandom_range(0, 1));
        dbits = 5'($urandom_range(0, 31));
      end
      set_config(odd, dbits);
      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        if (i == BEATS_PER_PHASE / 2) drain_results();
        drive_beat(random_beat());
      end
      drain_results();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    kind_i            = KIND_ENCODE;
    data_in_i         = '0;
    codeword_in_i     = '0;
    extra_parity_in_i = 1'b0;
    out_stall_i       = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    sb                = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    fork
      receive_results();
    join_none
    run_directed();
    run_random();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hsc_pkg.sv
rtl/hsc_codec.sv
rtl/hamming_secded_codec.sv
rtl/hsc_checker.sv
sim/tb_hamming_secded_codec.sv
